// ===== sv/assert_macros.svh =====
// Assertion macros shared by the repetition timing tester RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed: implication does not hold");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication does not hold");

`endif

// ===== sv/rtt_pkg.sv =====
// Types and constants for the repetition timing tester.
// No dependencies; imported by every module of the block.
`default_nettype none

package rtt_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_RUNNING  = 2'd1;
  localparam logic [1:0] MODE_ERROR    = 2'd2;
  localparam logic [1:0] MODE_FINISHED = 2'd3;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        still_running;
    logic        new_minimum;
    logic [63:0] repetition_count;
    logic [63:0] total_ticks;
    logic [63:0] min_ticks;
    logic [63:0] max_ticks;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/rtt_in_reg.sv =====
// Input register of the repetition timing tester.
// Depends on rtt_pkg; feeds rtt_engine.
`default_nettype none

module rtt_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rtt_pkg::in_item_t in_data,
  input  wire logic              take,
  output logic                   item_valid,
  output rtt_pkg::in_item_t      item
);
  import rtt_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rtt_engine.sv =====
// Run state, statistics update and result register of the repetition timing tester.
// Depends on rtt_pkg and assert_macros.svh; takes items from rtt_in_reg.
`default_nettype none

module rtt_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [63:0]       timeout_ticks,
  input  wire logic              item_valid,
  input  wire rtt_pkg::in_item_t item,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rtt_pkg::out_item_t     out_data
);
  import rtt_pkg::*;
  `include "assert_macros.svh"

  logic [1:0]  mode_r,  mode_nxt;
  logic [31:0] open_r,  open_nxt;
  logic [31:0] close_r, close_nxt;
  logic [63:0] acc_r,   acc_nxt;
  logic [63:0] reps_r,  reps_nxt;
  logic [63:0] total_r, total_nxt;
  logic [63:0] min_r,   min_nxt;
  logic [63:0] max_r,   max_nxt;
  logic [63:0] wave_r,  wave_nxt;
  logic        fresh;
  logic [63:0] elapsed;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r;

  assign take      = item_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign elapsed   = item.timestamp - wave_r;

  always_comb begin
    mode_nxt  = mode_r;
    open_nxt  = open_r;
    close_nxt = close_r;
    acc_nxt   = acc_r;
    reps_nxt  = reps_r;
    total_nxt = total_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    wave_nxt  = wave_r;
    fresh     = 1'b0;
    case (item.operation)
      OP_START: begin
        if (mode_r == MODE_IDLE) begin
          mode_nxt = MODE_RUNNING;
          min_nxt  = ALL_ONES;
        end else if (mode_r == MODE_FINISHED) begin
          mode_nxt = MODE_RUNNING;
        end
        wave_nxt = item.timestamp;
      end
      OP_BEGIN: begin
        open_nxt = open_r + 32'd1;
        acc_nxt  = acc_r - item.timestamp;
      end
      OP_END: begin
        close_nxt = close_r + 32'd1;
        acc_nxt   = acc_r + item.timestamp;
      end
      OP_CHECK: begin
        if (mode_r == MODE_RUNNING) begin
          if (open_r != 32'd0) begin
            if (close_r != open_r) begin
              mode_nxt = MODE_ERROR;
            end else begin
              reps_nxt  = reps_r + 64'd1;
              total_nxt = total_r + acc_r;
              if (max_r < acc_r) begin
                max_nxt = acc_r;
              end
              if (min_r > acc_r) begin
                min_nxt  = acc_r;
                wave_nxt = item.timestamp;
                fresh    = 1'b1;
              end
              open_nxt  = 32'd0;
              close_nxt = 32'd0;
              acc_nxt   = 64'd0;
            end
          end
          // a new minimum restarts the wave clock, so no timeout then
          if (!fresh && (elapsed > timeout_ticks)) begin
            mode_nxt = MODE_FINISHED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      open_r  <= 32'd0;
      close_r <= 32'd0;
      acc_r   <= 64'd0;
      reps_r  <= 64'd0;
      total_r <= 64'd0;
      min_r   <= 64'd0;
      max_r   <= 64'd0;
      wave_r  <= 64'd0;
    end else if (take) begin
      mode_r  <= mode_nxt;
      open_r  <= open_nxt;
      close_r <= close_nxt;
      acc_r   <= acc_nxt;
      reps_r  <= reps_nxt;
      total_r <= total_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      wave_r  <= wave_nxt;
    end
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r.mode             <= mode_nxt;
      out_r.still_running    <= (mode_nxt == MODE_RUNNING);
      out_r.new_minimum      <= fresh;
      out_r.repetition_count <= reps_nxt;
      out_r.total_ticks      <= total_nxt;
      out_r.min_ticks        <= min_nxt;
      out_r.max_ticks        <= max_nxt;
    end
  end

  `ASSERT_IMPLIES(a_running_flag, clk, rst_n, out_valid_r, out_r.still_running == (out_r.mode == MODE_RUNNING))
  `ASSERT_IMPLIES(a_fresh_keeps_running, clk, rst_n, out_valid_r && out_r.new_minimum, out_r.mode == MODE_RUNNING)
  `ASSERT_IMPLIES(a_fresh_bounded, clk, rst_n, out_valid_r && out_r.new_minimum, out_r.min_ticks <= out_r.max_ticks)
  `ASSERT_NEXT(a_take_loads_result, clk, rst_n, take, out_valid_r)

endmodule

`default_nettype wire

// ===== sv/repetition_timing_tester_top.sv =====
// Repetition timing tester: takes timestamped timing events, keeps min/max statistics.
// Channels: in_* carries one event (operation, timestamp) per transfer; out_*
// carries one result (mode and statistics after the event) per event; cfg_*
// writes the 64-bit timeout in ticks and is always ready.
// An accepted event lands in the input register; once the result register is free
// or being read, the event is folded into the run state and loads the result
// register. One event per cycle is sustained while the receiver takes every
// result: the input register and the result register both advance in the same cycle.
// When the receiver stalls the result holds and one more event can wait in the
// input register; in_ready then drops until the result is taken.
// Synchronous reset (rst_n low) clears mode to idle, all counts and statistics
// to zero and the timeout to zero; both registers come up empty.
// Configuration is to be written only while no event is in flight; the block does not enforce it.
// Depends on rtt_pkg, rtt_in_reg and rtt_engine.
`default_nettype none

module repetition_timing_tester_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rtt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rtt_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [63:0]        cfg_data
);
  import rtt_pkg::*;

  logic [63:0] timeout_r;
  logic        item_valid;
  in_item_t    item;
  logic        take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  rtt_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rtt_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .timeout_ticks (timeout_r),
    .item_valid    (item_valid),
    .item          (item),
    .take          (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire
